// ----- rtl/twrpr_pkg.sv -----
// ----------------------------------------------------------------------------
// twrpr_pkg
// Shared types, codes and frame constants of the ranging poll responder.
// ----------------------------------------------------------------------------
package twrpr_pkg;

	typedef enum logic [1:0] {
		OP_RX_BYTE   = 2'd0,
		OP_FRAME_END = 2'd1,
		OP_TX_DONE   = 2'd2
	} op_t;

	localparam logic [1:0] REG_REPLY_DELAY = 2'd0;
	localparam logic [1:0] REG_ANT_DELAY   = 2'd1;

	localparam logic [15:0] REPLY_DELAY_RST = 16'd1100;
	localparam logic [15:0] ANT_DELAY_RST   = 16'd0;

	localparam int unsigned HDR_LEN  = 10;
	localparam int unsigned SEQ_POS  = 2;
	localparam int unsigned RESP_LEN = 20;

	localparam logic [4:0] RESP_RX_POS   = 5'd10;
	localparam logic [4:0] RESP_TX_POS   = 5'd14;
	localparam logic [4:0] RESP_PAD_POS  = 5'd18;
	localparam logic [4:0] RESP_LAST_POS = 5'd19;

	typedef struct packed {
		logic [7:0]  seq;
		logic [31:0] rx_lo;
		logic [31:0] sched;
		logic [31:0] polls;
		logic [31:0] sent;
	} resp_t;

	function automatic logic [7:0] poll_hdr_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h41;
			4'd1:    b = 8'h88;
			4'd2:    b = 8'h00;
			4'd3:    b = 8'hCA;
			4'd4:    b = 8'hDE;
			4'd5:    b = 8'h57;
			4'd6:    b = 8'h41;
			4'd7:    b = 8'h56;
			4'd8:    b = 8'h45;
			4'd9:    b = 8'hE0;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] resp_hdr_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h41;
			4'd1:    b = 8'h88;
			4'd2:    b = 8'h00;
			4'd3:    b = 8'hCA;
			4'd4:    b = 8'hDE;
			4'd5:    b = 8'h56;
			4'd6:    b = 8'h45;
			4'd7:    b = 8'h57;
			4'd8:    b = 8'h41;
			4'd9:    b = 8'hE1;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/twrpr_resp_tx.sv -----
// ----------------------------------------------------------------------------
// twrpr_resp_tx
// Holds one response and sends its 20 bytes, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module twrpr_resp_tx (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  twrpr_pkg::resp_t  load_resp,
	input  logic [15:0]       antenna_delay,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        tx_byte,
	output logic              tx_last,
	output logic [31:0]       delayed_tx_time,
	output logic [31:0]       poll_count,
	output logic [31:0]       sent_count
);

	logic             busy_q;
	logic [4:0]       idx_q;
	twrpr_pkg::resp_t resp_q;
	logic [31:0]      txts_q;
	logic             last_pos;
	logic             done;
	logic [4:0]       rx_off;
	logic [4:0]       tx_off;

	assign last_pos   = (idx_q == twrpr_pkg::RESP_LAST_POS);
	assign done       = busy_q && out_ready && last_pos;
	assign load_ready = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load_valid && load_ready) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 5'd1;
		end
	end

	// The predicted transmit time is registered from the held record, well before
	// its bytes are sent.
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			resp_q <= load_resp;
		end
		txts_q <= {resp_q.sched[23:1], 9'd0} + {16'd0, antenna_delay};
	end

	assign rx_off = idx_q - twrpr_pkg::RESP_RX_POS;
	assign tx_off = idx_q - twrpr_pkg::RESP_TX_POS;

	always_comb begin
		if (idx_q < twrpr_pkg::RESP_RX_POS) begin
			if (idx_q == 5'(twrpr_pkg::SEQ_POS)) begin
				tx_byte = resp_q.seq;
			end else begin
				tx_byte = twrpr_pkg::resp_hdr_byte(idx_q[3:0]);
			end
		end else if (idx_q < twrpr_pkg::RESP_TX_POS) begin
			tx_byte = resp_q.rx_lo[{rx_off[1:0], 3'd0} +: 8];
		end else if (idx_q < twrpr_pkg::RESP_PAD_POS) begin
			tx_byte = txts_q[{tx_off[1:0], 3'd0} +: 8];
		end else begin
			tx_byte = 8'h00;
		end
	end

	assign out_valid       = busy_q;
	assign tx_last         = last_pos;
	assign delayed_tx_time = resp_q.sched;
	assign poll_count      = resp_q.polls;
	assign sent_count      = resp_q.sent;

endmodule

// ----- rtl/twr_poll_responder_top.sv -----
// ----------------------------------------------------------------------------
// twr_poll_responder_top
// Responder of single-sided two-way ranging: checks received poll frames and
// sends a timestamped response frame for each good poll.
// ----------------------------------------------------------------------------
// A frame end item is registered at the input, and its response is loaded into
// the sender. One input item per cycle; a poll's 20 response bytes go out one
// per cycle when not stalled; a later good poll waits only while they drain.
// Reset clears all counters and the receive state; the delay registers return
// to 1100 and 0.
module twr_poll_responder_top #(
	parameter int unsigned RX_BUFFER_BYTES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  rx_byte,
	input  logic        frame_good,
	input  logic [39:0] rx_timestamp,
	input  logic        tx_ok,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	output logic [31:0] delayed_tx_time,
	output logic [31:0] poll_count,
	output logic [31:0] sent_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [5:0] BUF_BYTES = 6'(RX_BUFFER_BYTES);
	localparam logic [5:0] HDR_BYTES = 6'(twrpr_pkg::HDR_LEN);
	localparam logic [5:0] SEQ_BYTE  = 6'(twrpr_pkg::SEQ_POS);

	logic [15:0]      reply_delay_q;
	logic [15:0]      ant_delay_q;
	logic [5:0]       byte_index_q;
	logic             header_match_q;
	logic [7:0]       seq_q;
	logic [31:0]      polls_q;
	logic [31:0]      sent_q;

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [7:0]       byte_s1;
	logic             good_s1;
	logic [39:0]      ts_s1;
	logic             tx_ok_s1;

	logic             hit;
	logic             advance;
	logic             load_ready;
	logic             byte_bad;
	logic [39:0]      sched_sum;
	twrpr_pkg::resp_t resp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_delay_q <= twrpr_pkg::REPLY_DELAY_RST;
			ant_delay_q   <= twrpr_pkg::ANT_DELAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				twrpr_pkg::REG_REPLY_DELAY: reply_delay_q <= cfg_data;
				twrpr_pkg::REG_ANT_DELAY:   ant_delay_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hit = valid_s1 && (op_s1 == twrpr_pkg::OP_FRAME_END) && good_s1 &&
		header_match_q && (byte_index_q >= HDR_BYTES) && (byte_index_q <= BUF_BYTES);
	assign advance  = valid_s1 && (!hit || load_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= op;
			byte_s1  <= rx_byte;
			good_s1  <= frame_good;
			ts_s1    <= rx_timestamp;
			tx_ok_s1 <= tx_ok;
		end
	end

	always_comb begin
		byte_bad = 1'b0;
		if (byte_index_q >= BUF_BYTES) begin
			byte_bad = 1'b1;
		end else if (byte_index_q < HDR_BYTES && byte_index_q != SEQ_BYTE) begin
			byte_bad = (byte_s1 != twrpr_pkg::poll_hdr_byte(byte_index_q[3:0]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			header_match_q <= 1'b1;
			seq_q          <= '0;
			polls_q        <= '0;
			sent_q         <= '0;
		end else if (advance) begin
			case (op_s1)
				twrpr_pkg::OP_RX_BYTE: begin
					if (byte_bad) begin
						header_match_q <= 1'b0;
					end
					if (byte_index_q != 6'd63) begin
						byte_index_q <= byte_index_q + 6'd1;
					end
				end
				twrpr_pkg::OP_FRAME_END: begin
					byte_index_q   <= '0;
					header_match_q <= 1'b1;
					if (hit) begin
						polls_q <= polls_q + 32'd1;
					end
				end
				twrpr_pkg::OP_TX_DONE: begin
					if (tx_ok_s1) begin
						sent_q <= sent_q + 32'd1;
						seq_q  <= seq_q + 8'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign sched_sum   = ts_s1 + {8'd0, reply_delay_q, 16'd0};
	assign resp.seq    = seq_q;
	assign resp.rx_lo  = ts_s1[31:0];
	assign resp.sched  = sched_sum[39:8];
	assign resp.polls  = polls_q + 32'd1;
	assign resp.sent   = sent_q;

	twrpr_resp_tx u_resp_tx (
		.clk             (clk),
		.arst_n          (arst_n),
		.load_valid      (hit),
		.load_ready      (load_ready),
		.load_resp       (resp),
		.antenna_delay   (ant_delay_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_byte         (tx_byte),
		.tx_last         (tx_last),
		.delayed_tx_time (delayed_tx_time),
		.poll_count      (poll_count),
		.sent_count      (sent_count)
	);

endmodule

// ----- verif/twr_poll_responder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twr_poll_responder_top_tb
// Drives received frame bytes, frame ends and transmit outcomes into the poll
// responder and checks every response byte against a local prediction of the
// header check, the counters and the timestamp arithmetic, under several
// delay settings and with random stalls on both sides.
// ----------------------------------------------------------------------------
module twr_poll_responder_top_tb;

	localparam int RX_BUF_BYTES = 24;
	localparam int SETTLE = 8;
	localparam int LONG_STALL = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [79:0] POLL_HDR = 80'h41_88_00_CA_DE_57_41_56_45_E0;
	localparam logic [79:0] RESP_HDR = 80'h41_88_00_CA_DE_56_45_57_41_E1;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  rx_byte;
		logic        good;
		logic [39:0] ts;
		logic        tx_ok;
	} rx_item_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] sched;
		logic [31:0] polls;
		logic [31:0] sent;
	} resp_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = twrpr_pkg::OP_RX_BYTE;
	logic [7:0]  rx_byte = 8'd0;
	logic        frame_good = 1'b0;
	logic [39:0] rx_timestamp = 40'd0;
	logic        tx_ok = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  tx_byte;
	logic        tx_last;
	logic [31:0] delayed_tx_time;
	logic [31:0] poll_count;
	logic [31:0] sent_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = twrpr_pkg::REG_REPLY_DELAY;
	logic [15:0] cfg_data = 16'd0;

	// Local copy of the responder state and its registers.
	logic [5:0]  frame_len = 6'd0;
	logic        rx_hdr_ok = 1'b1;
	logic [7:0]  seq_no = 8'd0;
	logic [31:0] polls_done = 32'd0;
	logic [31:0] replies_sent = 32'd0;
	logic [15:0] delay_units = twrpr_pkg::REPLY_DELAY_RST;
	logic [15:0] ant_ticks = twrpr_pkg::ANT_DELAY_RST;

	rx_item_t   items_to_send[$];
	resp_byte_t resp_due[$];
	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned cfg_taken = 0;
	int unsigned hold_asked = 0;
	int unsigned hold_given = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_left = 0;
	logic in_fire = 1'b0;

	twr_poll_responder_top #(
		.RX_BUFFER_BYTES(RX_BUF_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.rx_byte(rx_byte),
		.frame_good(frame_good),
		.rx_timestamp(rx_timestamp),
		.tx_ok(tx_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte(tx_byte),
		.tx_last(tx_last),
		.delayed_tx_time(delayed_tx_time),
		.poll_count(poll_count),
		.sent_count(sent_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic log_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
	endtask

	task automatic predict_response(input rx_item_t it);
		resp_byte_t rb;
		logic [63:0] sum;
		logic [31:0] sched;
		logic [31:0] txts;
		logic [79:0] hdr;
		logic [159:0] frame;
		case (it.op)
			twrpr_pkg::OP_RX_BYTE: begin
				if (frame_len >= RX_BUF_BYTES) begin
					rx_hdr_ok = 1'b0;
				end else if (frame_len < twrpr_pkg::HDR_LEN &&
						frame_len != twrpr_pkg::SEQ_POS) begin
					if (it.rx_byte != POLL_HDR[79 - 8 * frame_len -: 8]) begin
						rx_hdr_ok = 1'b0;
					end
				end
				if (frame_len != 6'd63) begin
					frame_len = frame_len + 6'd1;
				end
			end
			twrpr_pkg::OP_FRAME_END: begin
				if (it.good && rx_hdr_ok && frame_len >= twrpr_pkg::HDR_LEN &&
						frame_len <= RX_BUF_BYTES) begin
					polls_done = polls_done + 32'd1;
					sum = {24'd0, it.ts} + ({48'd0, delay_units} << 16);
					sched = sum[39:8];
					txts = {sched[23:1], 1'b0, 8'h00} + {16'd0, ant_ticks};
					hdr = RESP_HDR;
					hdr[79 - 8 * twrpr_pkg::SEQ_POS -: 8] = seq_no;
					frame = {hdr, it.ts[7:0], it.ts[15:8], it.ts[23:16], it.ts[31:24],
						txts[7:0], txts[15:8], txts[23:16], txts[31:24], 16'h0000};
					for (int k = 0; k < twrpr_pkg::RESP_LEN; k++) begin
						rb.data = frame[159 - 8 * k -: 8];
						rb.last = (k == twrpr_pkg::RESP_LEN - 1);
						rb.sched = sched;
						rb.polls = polls_done;
						rb.sent = replies_sent;
						resp_due.push_back(rb);
					end
				end
				frame_len = 6'd0;
				rx_hdr_ok = 1'b1;
			end
			twrpr_pkg::OP_TX_DONE: begin
				if (it.tx_ok) begin
					replies_sent = replies_sent + 32'd1;
					seq_no = seq_no + 8'd1;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin : monitor
		rx_item_t seen;
		resp_byte_t want;
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				seen.op = op;
				seen.rx_byte = rx_byte;
				seen.good = frame_good;
				seen.ts = rx_timestamp;
				seen.tx_ok = tx_ok;
				predict_response(seen);
				items_taken++;
			end
			if (out_valid && out_ready) begin
				if (resp_due.size() == 0) begin
					log_mismatch("response byte with none due", 64'(tx_byte), 64'd0);
				end else begin
					want = resp_due.pop_front();
					if (tx_byte !== want.data)
						log_mismatch("tx_byte", 64'(tx_byte), 64'(want.data));
					if (tx_last !== want.last)
						log_mismatch("tx_last", 64'(tx_last), 64'(want.last));
					if (delayed_tx_time !== want.sched)
						log_mismatch("delayed_tx_time", 64'(delayed_tx_time),
							64'(want.sched));
					if (poll_count !== want.polls)
						log_mismatch("poll_count", 64'(poll_count), 64'(want.polls));
					if (sent_count !== want.sent)
						log_mismatch("sent_count", 64'(sent_count), 64'(want.sent));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					twrpr_pkg::REG_REPLY_DELAY: delay_units = cfg_data;
					twrpr_pkg::REG_ANT_DELAY:   ant_ticks = cfg_data;
					default: begin
					end
				endcase
				cfg_taken++;
			end
		end
	end

	always @(negedge clk) begin : driver
		rx_item_t nxt;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = items_to_send.pop_front();
				in_valid <= 1'b1;
				op <= nxt.op;
				rx_byte <= nxt.rx_byte;
				frame_good <= nxt.good;
				rx_timestamp <= nxt.ts;
				tx_ok <= nxt.tx_ok;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else if (hold_asked != hold_given) begin
			hold_given = hold_asked;
			stall_left = LONG_STALL;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("twr_poll_responder_top_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [39:0] rand40();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(7))
			0: return '1;
			1: return '0;
			default: return r[39:0];
		endcase
	endfunction

	function automatic rx_item_t noise_item();
		rx_item_t it;
		it.op = OP_UNUSED;
		it.rx_byte = 8'($urandom_range(255));
		it.good = 1'($urandom_range(1));
		it.ts = rand40();
		it.tx_ok = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic push_item(input rx_item_t it);
		items_to_send.push_back(it);
		items_queued++;
	endtask

	// A frame of len bytes with the poll header; bad_pos, when in range, gets a
	// corrupted byte.
	task automatic queue_frame(input int len, input logic good, input int bad_pos,
			input logic [39:0] ts);
		rx_item_t it;
		logic [7:0] b;
		for (int k = 0; k < len; k++) begin
			it = noise_item();
			it.op = twrpr_pkg::OP_RX_BYTE;
			if (k < twrpr_pkg::HDR_LEN && k != twrpr_pkg::SEQ_POS) begin
				b = POLL_HDR[79 - 8 * k -: 8];
			end else begin
				b = 8'($urandom_range(255));
			end
			if (k == bad_pos) begin
				b = b ^ 8'($urandom_range(255, 1));
			end
			it.rx_byte = b;
			push_item(it);
		end
		it = noise_item();
		it.op = twrpr_pkg::OP_FRAME_END;
		it.good = good;
		it.ts = ts;
		push_item(it);
	endtask

	task automatic queue_tx(input logic ok);
		rx_item_t it;
		it = noise_item();
		it.op = twrpr_pkg::OP_TX_DONE;
		it.tx_ok = ok;
		push_item(it);
	endtask

	task automatic queue_random(input int n);
		int made;
		int pick;
		int len;
		rx_item_t it;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				len = $urandom_range(RX_BUF_BYTES, twrpr_pkg::HDR_LEN);
				queue_frame(len, $urandom_range(9) != 0, -1, rand40());
				made += len + 1;
				if ($urandom_range(9) < 7) begin
					queue_tx($urandom_range(4) != 0);
					made++;
				end
			end else if (pick < 65) begin
				len = $urandom_range(RX_BUF_BYTES, twrpr_pkg::HDR_LEN);
				queue_frame(len, 1'b1, $urandom_range(twrpr_pkg::HDR_LEN - 1), rand40());
				made += len + 1;
			end else if (pick < 72) begin
				len = $urandom_range(twrpr_pkg::HDR_LEN - 1);
				queue_frame(len, 1'b1, -1, rand40());
				made += len + 1;
			end else if (pick < 78) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(70, 64)
					: $urandom_range(RX_BUF_BYTES + 6, RX_BUF_BYTES + 1);
				queue_frame(len, 1'b1, -1, rand40());
				made += len + 1;
			end else if (pick < 84) begin
				len = $urandom_range(RX_BUF_BYTES, twrpr_pkg::HDR_LEN);
				queue_frame(len, 1'b0, -1, rand40());
				made += len + 1;
			end else if (pick < 92) begin
				queue_tx(1'($urandom_range(1)));
				made++;
			end else if (pick < 96) begin
				push_item(noise_item());
			end else begin
				it = noise_item();
				it.op = twrpr_pkg::OP_RX_BYTE;
				push_item(it);
				made++;
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		int unsigned seen;
		seen = cfg_taken;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (cfg_taken == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (items_taken != items_queued || resp_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin : main
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset register values, extreme timestamps and lengths, every operation.
		@(posedge clk);
		queue_frame(twrpr_pkg::HDR_LEN, 1'b1, -1, '1);
		queue_tx(1'b1);
		queue_tx(1'b0);
		push_item(noise_item());
		queue_frame(0, 1'b1, -1, rand40());
		queue_frame(RX_BUF_BYTES, 1'b1, -1, '0);
		settle();

		write_reg(twrpr_pkg::REG_REPLY_DELAY, 16'hFFFF);
		write_reg(twrpr_pkg::REG_ANT_DELAY, 16'hFFFF);
		@(posedge clk);
		send_idle_pct = 23;
		recv_idle_pct = 63;
		queue_random(30);
		settle();

		write_reg(twrpr_pkg::REG_REPLY_DELAY, 16'h0000);
		write_reg(twrpr_pkg::REG_ANT_DELAY, 16'h0000);
		@(posedge clk);
		send_idle_pct = 63;
		recv_idle_pct = 23;
		queue_random(30);
		settle();

		write_reg(twrpr_pkg::REG_REPLY_DELAY, 16'($urandom));
		write_reg(twrpr_pkg::REG_ANT_DELAY, 16'($urandom));
		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(30);
		settle();

		// The receiver stops for a long stretch while polls keep coming.
		@(posedge clk);
		hold_asked++;
		for (int p = 0; p < 4; p++) begin
			queue_frame(twrpr_pkg::HDR_LEN, 1'b1, -1, rand40());
			queue_tx(1'b1);
		end
		settle();

		if (error_count == 0) begin
			$display("twr_poll_responder_top_tb: done, clean");
		end else begin
			$display("twr_poll_responder_top_tb: done, errors");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/twrpr_pkg.sv
rtl/twrpr_resp_tx.sv
rtl/twr_poll_responder_top.sv
verif/twr_poll_responder_top_tb.sv
